// ===== hdl/tterm_pkg.sv =====
// Shared constants and types for the text terminal cursor engine.
// No dependencies.
package tterm_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int TAB_W  = 5;
  localparam int CHAR_W = 7;
  localparam int ESC_W  = 2;

  localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

  localparam logic [ESC_W-1:0] ESC_NORMAL = 2'd0;
  localparam logic [ESC_W-1:0] ESC_CSI    = 2'd1;
  localparam logic [ESC_W-1:0] ESC_START  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [ESC_W-1:0] esc;
  } cursor_state_t;

  typedef struct packed {
    logic              write_enable;
    logic [COL_W-1:0]  write_col;
    logic [ROW_W-1:0]  write_row;
    logic [CHAR_W-1:0] write_char;
    logic              clear_screen;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } result_t;

endpackage

// ===== hdl/tterm_step.sv =====
// Combinational handling of one byte: cursor motion, wrap, clear, escape tracking.
// Depends on tterm_pkg.
module tterm_step import tterm_pkg::*; (
  input  cursor_state_t    state,
  input  logic [7:0]       byte_in,
  input  logic [TAB_W-1:0] tab_width,
  output cursor_state_t    state_next,
  output result_t          result
);

  localparam logic [7:0] COLUMNS_X = 8'(COLUMNS);
  localparam logic [5:0] ROWS_X    = 6'(ROWS);

  logic [7:0] col;
  logic [5:0] row;
  logic       clr;
  logic       we;
  logic [CHAR_W-1:0] wch;
  logic [COL_W-1:0]  wcol;
  logic [ROW_W-1:0]  wrow;
  logic [ESC_W-1:0]  esc;
  logic       is_param;
  logic       printable;

  assign is_param  = (byte_in >= CH_ZERO && byte_in <= CH_NINE) ||
                     byte_in == CH_SEMI || byte_in == CH_QUEST;
  assign printable = byte_in >= CH_SPACE && byte_in <= CH_TILDE;

  always_comb begin
    col  = {1'b0, state.col};
    row  = {1'b0, state.row};
    esc  = state.esc;
    clr  = 1'b0;
    we   = 1'b0;
    wch  = '0;
    wcol = '0;
    wrow = '0;
    // out-of-range cursor on entry: clear and home first
    if (col >= COLUMNS_X || row >= ROWS_X) begin
      col = '0;
      row = '0;
      clr = 1'b1;
    end
    if (state.esc != ESC_NORMAL) begin
      if (state.esc == ESC_START && byte_in == CH_LBRK) begin
        esc = ESC_CSI;
      end else if (!is_param) begin
        esc = ESC_NORMAL;
      end
    end else if (byte_in != CH_NUL) begin
      unique case (byte_in)
        CH_LF, CH_VT, CH_FF: begin
          col = '0;
          row = row + 6'd1;
        end
        CH_BS, CH_DEL: begin
          we   = 1'b1;
          wch  = CH_SPACE[CHAR_W-1:0];
          wcol = col[COL_W-1:0];
          wrow = row[ROW_W-1:0];
          if (col != '0) begin
            col = col - 8'd1;
          end
        end
        CH_CR: begin
          col = '0;
        end
        CH_TAB: begin
          col = col + {3'b0, tab_width};
        end
        CH_ESC: begin
          esc = ESC_START;
        end
        default: begin
          we   = 1'b1;
          wch  = printable ? byte_in[CHAR_W-1:0] : CH_QUEST[CHAR_W-1:0];
          wcol = col[COL_W-1:0];
          wrow = row[ROW_W-1:0];
          col  = col + 8'd1;
        end
      endcase
      if (col >= COLUMNS_X) begin
        col = '0;
        row = row + 6'd1;
      end
      if (row >= ROWS_X) begin
        col = '0;
        row = '0;
        clr = 1'b1;
      end
    end
  end

  assign state_next.col = col[COL_W-1:0];
  assign state_next.row = row[ROW_W-1:0];
  assign state_next.esc = esc;

  assign result.write_enable = we;
  assign result.write_col    = wcol;
  assign result.write_row    = wrow;
  assign result.write_char   = wch;
  assign result.clear_screen = clr;
  assign result.cursor_col   = col[COL_W-1:0];
  assign result.cursor_row   = row[ROW_W-1:0];

endmodule

// ===== hdl/text_terminal_cursor_engine_unit.sv =====
// Text terminal cursor engine: one byte in, one cell write and cursor result out.
// A byte is taken into a hold register; its result is then registered in the result register.
// Throughput: one item per cycle while out_stall is low; cursor and escape state update as an item enters the
// result register, so the next byte sees it at once.
// Reset (synchronous): cursor at 0,0, normal text mode, tab width 4, pipeline empty.
// Depends on tterm_pkg and tterm_step.
module text_terminal_cursor_engine_unit import tterm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              write_enable,
  output logic [COL_W-1:0]  write_col,
  output logic [ROW_W-1:0]  write_row,
  output logic [CHAR_W-1:0] write_char,
  output logic              clear_screen,
  output logic [COL_W-1:0]  cursor_col_out,
  output logic [ROW_W-1:0]  cursor_row_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TAB_W-1:0]  cfg_data
);

  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic [TAB_W-1:0] tab_width;
  cursor_state_t    state;
  cursor_state_t    state_next;
  result_t          result;
  logic             out_free;
  logic             advance;
  logic             in_accept;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = hold_valid && out_free;
  assign in_stall  = hold_valid && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  tterm_step u_step (
    .state      (state),
    .byte_in    (hold_byte),
    .tab_width  (tab_width),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      tab_width  <= TAB_RESET;
      state      <= '{col: '0, row: '0, esc: ESC_NORMAL};
    end else begin
      if (in_accept) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        tab_width <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_byte <= byte_in;
    end
    if (advance) begin
      write_enable   <= result.write_enable;
      write_col      <= result.write_col;
      write_row      <= result.write_row;
      write_char     <= result.write_char;
      clear_screen   <= result.clear_screen;
      cursor_col_out <= result.cursor_col;
      cursor_row_out <= result.cursor_row;
    end
  end

endmodule

// ===== hdl/tterm_checker.sv =====
// Port-level checks for the text terminal cursor engine, bound to the top level.
// Depends on tterm_pkg and text_terminal_cursor_engine_unit.
module tterm_checker import tterm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              write_enable,
  input logic [COL_W-1:0]  write_col,
  input logic [ROW_W-1:0]  write_row,
  input logic [CHAR_W-1:0] write_char,
  input logic              clear_screen,
  input logic [COL_W-1:0]  cursor_col_out,
  input logic [ROW_W-1:0]  cursor_row_out
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cursor_col_out) &&
      $stable(cursor_row_out) && $stable(write_char) && $stable(write_enable))
    else $error("result changed while stalled");

  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_col == '0 && write_row == '0 && write_char == '0)
    else $error("write fields not zero without a write");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_screen |-> cursor_col_out == '0 && cursor_row_out == '0)
    else $error("clear without cursor home");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(cursor_col_out) < COLUMNS && 32'(cursor_row_out) < ROWS)
    else $error("cursor out of range");

  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> write_char >= 7'h20 && write_char <= 7'h7E)
    else $error("unprintable character written");

endmodule

bind text_terminal_cursor_engine_unit tterm_checker u_tterm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .write_enable   (write_enable),
  .write_col      (write_col),
  .write_row      (write_row),
  .write_char     (write_char),
  .clear_screen   (clear_screen),
  .cursor_col_out (cursor_col_out),
  .cursor_row_out (cursor_row_out)
);
